FILE: src/eadh_pkg.sv
// Shared types, constants and helpers for the energy accumulator with daily history.
`timescale 1ns / 1ps

package eadh_pkg;

  // Field widths
  localparam int E_W         = 48;   // energy accumulator width
  localparam int WEEK_W      = 51;   // week sum width
  localparam int WEEK_CALC_W = 54;   // headroom for up to 64 summed days
  localparam int TIME_W      = 32;
  localparam int DELTA_W     = 32;
  localparam int TZ_W        = 5;

  localparam logic [E_W-1:0]    MAX48 = {E_W{1'b1}};
  localparam logic [WEEK_W-1:0] MAX51 = {WEEK_W{1'b1}};

  // Time constants; 86400 = 675 * 2^7
  localparam int SEC_PER_DAY   = 86400;
  localparam int SEC_PER_HOUR  = 3600;
  localparam int DAY_LOW_BITS  = 7;
  localparam int DAY_ODD       = 675;
  localparam int DAY_ODD_W     = 10;
  // floor(2^36 / 675): quotient estimate is exact or one low
  localparam int DIV_SHIFT     = 36;
  localparam int RECIP_W       = 27;
  localparam logic [RECIP_W-1:0] RECIP = 27'd101806632;
  localparam int Y_W           = 26;  // (local + day) >> 7
  localparam int Q_W           = 17;  // quotient of Y by 675
  localparam int PROD_W        = Y_W + RECIP_W;
  localparam int LOC_W         = 34;  // signed shifted local time

  // Decoupling queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Item class decided by the front end
  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_IN,
    KIND_OUT,
    KIND_TIME
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [DELTA_W-1:0]  mag;
    logic [TIME_W-1:0]   midnight;
  } item_t;

  typedef struct packed {
    logic [E_W-1:0]    day_in;
    logic [E_W-1:0]    day_out;
    logic [E_W-1:0]    lifetime_in;
    logic [E_W-1:0]    lifetime_out;
    logic [WEEK_W-1:0] week_in;
    logic [WEEK_W-1:0] week_out;
    logic [TIME_W-1:0] day_anchor;
    logic              rolled_over;
  } res_t;

  // Saturating add of a 32-bit magnitude to a 48-bit accumulator
  function automatic logic [E_W-1:0] sat_add48(logic [E_W-1:0] acc, logic [DELTA_W-1:0] add);
    logic [E_W:0] s;
    s = {1'b0, acc} + {{(E_W + 1 - DELTA_W){1'b0}}, add};
    return s[E_W] ? MAX48 : s[E_W-1:0];
  endfunction

endpackage

FILE: src/eadh_intf.sv
// Channel interfaces: input items, result items and the configuration write.
`timescale 1ns / 1ps

interface eadh_in_if;
  logic                valid;
  logic                ready;
  logic                action;
  logic signed [31:0]  delta_mwh;
  logic        [31:0]  now_seconds;

  modport source (output valid, action, delta_mwh, now_seconds, input ready);
  modport sink   (input valid, action, delta_mwh, now_seconds, output ready);
  modport mon    (input valid, ready, action, delta_mwh, now_seconds);
endinterface

interface eadh_out_if;
  logic         valid;
  logic         ready;
  logic [47:0]  day_in;
  logic [47:0]  day_out;
  logic [47:0]  lifetime_in;
  logic [47:0]  lifetime_out;
  logic [50:0]  week_in;
  logic [50:0]  week_out;
  logic [31:0]  day_anchor;
  logic         rolled_over;

  modport source (output valid, day_in, day_out, lifetime_in, lifetime_out,
                  week_in, week_out, day_anchor, rolled_over, input ready);
  modport sink   (input valid, day_in, day_out, lifetime_in, lifetime_out,
                  week_in, week_out, day_anchor, rolled_over, output ready);
  modport mon    (input valid, ready, day_in, day_out, lifetime_in, lifetime_out,
                  week_in, week_out, day_anchor, rolled_over);
endinterface

interface eadh_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [4:0]  tz_offset_hours;

  modport source (output valid, tz_offset_hours, input ready);
  modport sink   (input valid, tz_offset_hours, output ready);
  modport mon    (input valid, ready, tz_offset_hours);
endinterface

FILE: src/eadh_front.sv
// Front end: accepts items, classifies them and computes local midnight in two stages.
`timescale 1ns / 1ps

module eadh_front import eadh_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      action,
  input  logic signed [DELTA_W-1:0] delta_mwh,
  input  logic        [TIME_W-1:0]  now_seconds,
  input  logic                      cfg_we,
  input  logic signed [TZ_W-1:0]    cfg_tz,
  input  logic        [QCNT_W-1:0]  q_count,
  output logic                      push,
  output item_t                     push_item
);

  localparam int OCC_W = QCNT_W + 1;
  localparam int R_W   = Y_W + 1;

  logic signed [TZ_W-1:0] tz_r;

  logic                  s1_v_r,    s1_v_nxt;
  kind_t                 s1_kind_r;
  logic [DELTA_W-1:0]    s1_mag_r;
  logic [TIME_W-1:0]     s1_now_r;
  logic [Y_W-1:0]        s1_y_r;
  logic [DAY_LOW_BITS-1:0] s1_lo_r;

  logic                  s2_v_r;
  kind_t                 s2_kind_r;
  logic [DELTA_W-1:0]    s2_mag_r;
  logic [TIME_W-1:0]     s2_now_r;
  logic [Y_W-1:0]        s2_y_r;
  logic [DAY_LOW_BITS-1:0] s2_lo_r;
  logic [Q_W-1:0]        s2_q_r;

  logic [OCC_W-1:0]      occ;
  logic                  accept;
  logic signed [LOC_W-1:0] off_s;
  logic signed [LOC_W-1:0] loc_s;
  kind_t                 kind_c;
  logic [DELTA_W-1:0]    mag_c;
  logic [PROD_W-1:0]     prod;
  logic [R_W-1:0]        qm;
  logic [R_W-1:0]        r0;
  logic [R_W-1:0]        r1;
  logic [DAY_ODD_W+DAY_LOW_BITS-1:0] rem;

  // Hold the time zone; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tz_r <= '0;
    end else if (cfg_we) begin
      tz_r <= cfg_tz;
    end
  end

  // Admit an item only if the queue can take everything in flight
  always_comb begin
    occ      = OCC_W'(q_count) + OCC_W'(s1_v_r) + OCC_W'(s2_v_r);
    in_ready = occ < OCC_W'(QUEUE_DEPTH);
    accept   = in_valid && in_ready;
    s1_v_nxt = accept;
  end

  // Classify and shift local time by one day so it is never negative
  always_comb begin
    off_s = LOC_W'(tz_r) * LOC_W'(SEC_PER_HOUR);
    loc_s = $signed({{(LOC_W - TIME_W){1'b0}}, now_seconds}) + off_s + LOC_W'(SEC_PER_DAY);
    mag_c = delta_mwh[DELTA_W-1] ? (DELTA_W'(0) - delta_mwh) : delta_mwh;
    if (!action) begin
      if (delta_mwh == '0) begin
        kind_c = KIND_NOP;
      end else if (delta_mwh[DELTA_W-1]) begin
        kind_c = KIND_OUT;
      end else begin
        kind_c = KIND_IN;
      end
    end else begin
      kind_c = (now_seconds == '0) ? KIND_NOP : KIND_TIME;
    end
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
    if (accept) begin
      s1_kind_r <= kind_c;
      s1_mag_r  <= mag_c;
      s1_now_r  <= now_seconds;
      s1_y_r    <= loc_s[DAY_LOW_BITS+Y_W-1:DAY_LOW_BITS];
      s1_lo_r   <= loc_s[DAY_LOW_BITS-1:0];
    end
  end

  // Estimate quotient by 675 with a reciprocal multiply
  assign prod = PROD_W'(s1_y_r) * PROD_W'(RECIP);

  // Stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    if (s1_v_r) begin
      s2_kind_r <= s1_kind_r;
      s2_mag_r  <= s1_mag_r;
      s2_now_r  <= s1_now_r;
      s2_y_r    <= s1_y_r;
      s2_lo_r   <= s1_lo_r;
      s2_q_r    <= prod[DIV_SHIFT+Q_W-1:DIV_SHIFT];
    end
  end

  // Correct remainder, then subtract seconds since local midnight
  always_comb begin
    qm   = R_W'(s2_q_r) * R_W'(DAY_ODD);
    r0   = R_W'(s2_y_r) - qm;
    r1   = (r0 >= R_W'(DAY_ODD)) ? (r0 - R_W'(DAY_ODD)) : r0;
    rem  = {r1[DAY_ODD_W-1:0], s2_lo_r};
    push = s2_v_r;
    push_item.kind     = s2_kind_r;
    push_item.mag      = s2_mag_r;
    push_item.midnight = s2_now_r - TIME_W'(rem);
  end

endmodule

FILE: src/eadh_queue.sv
// Short queue of classified items between the front and back ends.
`timescale 1ns / 1ps

module eadh_queue import eadh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  item_t             push_item,
  input  logic              pop,
  output logic              head_valid,
  output item_t             head_item,
  output logic [QCNT_W-1:0] count
);

  item_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r,    cnt_nxt;

  // Advance pointers with wrap; the front never pushes into a full queue
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head_item  = slot_r[rd_ptr_r];
  assign count      = cnt_r;

endmodule

FILE: src/eadh_back.sv
// Back end: applies items to the accumulators and history, forms and holds results.
`timescale 1ns / 1ps

module eadh_back import eadh_pkg::*; #(
  parameter int HISTORY_DAYS = 7
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_valid,
  input  item_t q_item,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  localparam int HSW = E_W + $clog2(HISTORY_DAYS + 1);

  logic [E_W-1:0]    day_in_r,    day_in_nxt;
  logic [E_W-1:0]    day_out_r,   day_out_nxt;
  logic [E_W-1:0]    life_in_r,   life_in_nxt;
  logic [E_W-1:0]    life_out_r,  life_out_nxt;
  logic [E_W-1:0]    hist_in_r   [HISTORY_DAYS];
  logic [E_W-1:0]    hist_in_nxt [HISTORY_DAYS];
  logic [E_W-1:0]    hist_out_r  [HISTORY_DAYS];
  logic [E_W-1:0]    hist_out_nxt[HISTORY_DAYS];
  logic [HSW-1:0]    hsum_in_r,   hsum_in_nxt;
  logic [HSW-1:0]    hsum_out_r,  hsum_out_nxt;
  logic [TIME_W-1:0] anchor_r,    anchor_nxt;
  logic              pend_r,      pend_nxt;
  logic              roll_r,      roll_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              res_r,       res_nxt;

  logic                   form;
  logic                   roll_c;
  logic [WEEK_CALC_W-1:0] wk_in;
  logic [WEEK_CALC_W-1:0] wk_out;

  // Apply one item per cycle while the result register can drain
  always_comb begin
    form  = pend_r && (!out_valid_r || out_ready);
    q_pop = q_valid && (!pend_r || form);

    day_in_nxt    = day_in_r;
    day_out_nxt   = day_out_r;
    life_in_nxt   = life_in_r;
    life_out_nxt  = life_out_r;
    hist_in_nxt   = hist_in_r;
    hist_out_nxt  = hist_out_r;
    hsum_in_nxt   = hsum_in_r;
    hsum_out_nxt  = hsum_out_r;
    anchor_nxt    = anchor_r;
    roll_c        = 1'b0;

    if (q_pop) begin
      case (q_item.kind)
        KIND_IN: begin
          day_in_nxt  = sat_add48(day_in_r, q_item.mag);
          life_in_nxt = sat_add48(life_in_r, q_item.mag);
        end
        KIND_OUT: begin
          day_out_nxt  = sat_add48(day_out_r, q_item.mag);
          life_out_nxt = sat_add48(life_out_r, q_item.mag);
        end
        KIND_TIME: begin
          if (anchor_r == '0) begin
            anchor_nxt = q_item.midnight;
          end else if (q_item.midnight > anchor_r) begin
            // Roll the day: shift history, push today, clear today
            for (int i = 1; i < HISTORY_DAYS; i++) begin
              hist_in_nxt[i]  = hist_in_r[i-1];
              hist_out_nxt[i] = hist_out_r[i-1];
            end
            hist_in_nxt[0]  = day_in_r;
            hist_out_nxt[0] = day_out_r;
            hsum_in_nxt  = hsum_in_r - HSW'(hist_in_r[HISTORY_DAYS-1]) + HSW'(day_in_r);
            hsum_out_nxt = hsum_out_r - HSW'(hist_out_r[HISTORY_DAYS-1]) + HSW'(day_out_r);
            day_in_nxt    = '0;
            day_out_nxt   = '0;
            anchor_nxt    = q_item.midnight;
            roll_c        = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    pend_nxt = q_pop ? 1'b1 : (form ? 1'b0 : pend_r);
    roll_nxt = q_pop ? roll_c : roll_r;
  end

  // Form the result from the state left by the pending item
  always_comb begin
    wk_in  = {{(WEEK_CALC_W - E_W){1'b0}}, day_in_r}
           + {{(WEEK_CALC_W - HSW){1'b0}}, hsum_in_r};
    wk_out = {{(WEEK_CALC_W - E_W){1'b0}}, day_out_r}
           + {{(WEEK_CALC_W - HSW){1'b0}}, hsum_out_r};

    res_nxt = res_r;
    if (form) begin
      res_nxt.day_in       = day_in_r;
      res_nxt.day_out      = day_out_r;
      res_nxt.lifetime_in  = life_in_r;
      res_nxt.lifetime_out = life_out_r;
      res_nxt.week_in  = (|wk_in[WEEK_CALC_W-1:WEEK_W])  ? MAX51 : wk_in[WEEK_W-1:0];
      res_nxt.week_out = (|wk_out[WEEK_CALC_W-1:WEEK_W]) ? MAX51 : wk_out[WEEK_W-1:0];
      res_nxt.day_anchor   = anchor_r;
      res_nxt.rolled_over  = roll_r;
    end
    out_valid_nxt = form ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_in_r    <= '0;
      day_out_r   <= '0;
      life_in_r   <= '0;
      life_out_r  <= '0;
      for (int i = 0; i < HISTORY_DAYS; i++) begin
        hist_in_r[i]  <= '0;
        hist_out_r[i] <= '0;
      end
      hsum_in_r   <= '0;
      hsum_out_r  <= '0;
      anchor_r    <= '0;
      pend_r      <= 1'b0;
      roll_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      day_in_r    <= day_in_nxt;
      day_out_r   <= day_out_nxt;
      life_in_r   <= life_in_nxt;
      life_out_r  <= life_out_nxt;
      hist_in_r   <= hist_in_nxt;
      hist_out_r  <= hist_out_nxt;
      hsum_in_r   <= hsum_in_nxt;
      hsum_out_r  <= hsum_out_nxt;
      anchor_r    <= anchor_nxt;
      pend_r      <= pend_nxt;
      roll_r      <= roll_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

FILE: src/energy_accumulator_daily_history.sv
// Top level of the bidirectional energy meter with a rolling daily history.
//
// Channels: in_ch carries energy items (action 0, signed delta in mWh) and
// time items (action 1, unix seconds); out_ch returns exactly one result per
// item, in order; cfg_ch writes the signed time zone offset in hours and is
// always ready. A transfer happens on a rising edge with valid and ready high.
// An accepted item passes the midnight stages, the queue, the back-end state
// and result registers. Throughput: one item per cycle sustained while out_ch
// is not stalled; the front end spends two stages on the local midnight
// (reciprocal multiply, then remainder correction), the back end applies one
// item to the accumulators per cycle, and a four-entry queue sits between them.
// in_ch.ready drops once the queue plus the items in the midnight stages fill
// the queue; while out_ch stalls, the back end holds its pending result and
// stops draining the queue, so the front end then fills and stops.
// Reset (rst_n low, synchronous) clears all accumulators, the history, the
// day anchor, the time zone offset and every valid flag.
`timescale 1ns / 1ps

module energy_accumulator_daily_history import eadh_pkg::*; #(
  parameter int HISTORY_DAYS = 7
) (
  input logic        clk,
  input logic        rst_n,
  eadh_in_if.sink    in_ch,
  eadh_out_if.source out_ch,
  eadh_cfg_if.sink   cfg_ch
);

  logic              push;
  item_t             push_item;
  logic              q_valid;
  item_t             q_item;
  logic              q_pop;
  logic [QCNT_W-1:0] q_count;
  logic              cfg_we;
  res_t              res;

  // Configuration is accepted every cycle
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  eadh_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .action      (in_ch.action),
    .delta_mwh   (in_ch.delta_mwh),
    .now_seconds (in_ch.now_seconds),
    .cfg_we      (cfg_we),
    .cfg_tz      (cfg_ch.tz_offset_hours),
    .q_count     (q_count),
    .push        (push),
    .push_item   (push_item)
  );

  eadh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_item),
    .count      (q_count)
  );

  eadh_back #(
    .HISTORY_DAYS (HISTORY_DAYS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  // Drive result payload
  assign out_ch.day_in       = res.day_in;
  assign out_ch.day_out      = res.day_out;
  assign out_ch.lifetime_in  = res.lifetime_in;
  assign out_ch.lifetime_out = res.lifetime_out;
  assign out_ch.week_in      = res.week_in;
  assign out_ch.week_out     = res.week_out;
  assign out_ch.day_anchor   = res.day_anchor;
  assign out_ch.rolled_over  = res.rolled_over;

endmodule

FILE: src/eadh_checker.sv
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps

module eadh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] day_in,
  input logic [47:0] day_out,
  input logic [47:0] lifetime_in,
  input logic [47:0] lifetime_out,
  input logic [50:0] week_in,
  input logic [50:0] week_out,
  input logic [31:0] day_anchor,
  input logic        rolled_over
);

  // Hold a stalled result: valid, day_in, week_in and day_anchor stay
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(day_in)
      && $stable(week_in) && $stable(day_anchor))
    else $error("result changed while stalled");

  // A rollover leaves today cleared
  a_roll_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && rolled_over |-> day_in == '0 && day_out == '0)
    else $error("rollover result with nonzero today");

  // Lifetime never trails today
  a_life_ge_today: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> lifetime_in >= day_in && lifetime_out >= day_out)
    else $error("lifetime below today");

  // Week sums include today
  a_week_ge_today: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> week_in >= 51'(day_in) && week_out >= 51'(day_out))
    else $error("week sum below today");

endmodule

bind energy_accumulator_daily_history eadh_checker u_eadh_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .day_in       (out_ch.day_in),
  .day_out      (out_ch.day_out),
  .lifetime_in  (out_ch.lifetime_in),
  .lifetime_out (out_ch.lifetime_out),
  .week_in      (out_ch.week_in),
  .week_out     (out_ch.week_out),
  .day_anchor   (out_ch.day_anchor),
  .rolled_over  (out_ch.rolled_over)
);
